// ----- rtl/pscga_pkg.sv -----
// Package for the polar scan grid accumulator: payload structs, queue entry,
// command and register codes, fixed-point constants and the arctangent table.
// No dependencies.
package pscga_pkg;

	localparam int CFG_DATA_W   = 27;
	localparam int ANGLE_W      = 39;
	localparam int RED_W        = 38;
	localparam int Z_W          = 29;
	localparam int XY_W         = 20;
	localparam int CORDIC_ITERS = 16;
	localparam int RED_STEPS    = 11;
	localparam int COORD_FRAC   = 24;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [1:0] CMD_ACC = 2'd0;
	localparam logic [1:0] CMD_CLR = 2'd1;
	localparam logic [1:0] CMD_RD  = 2'd2;

	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_STEP  = 2'd1;
	localparam logic [1:0] CFG_LIMIT = 2'd2;

	localparam logic RES_POINT = 1'b0;
	localparam logic RES_READ  = 1'b1;

	localparam logic [15:0] LIMIT_RESET = 16'd1280;
	localparam logic [7:0]  CELL_STEP   = 8'd20;

	localparam logic [RED_W-1:0]          TWO_PI_R     = 38'd105414357;
	localparam logic signed [ANGLE_W-1:0] TWO_PI_A     = 39'sd105414357;
	localparam logic signed [Z_W-1:0]     TWO_PI_Z     = 29'sd105414357;
	localparam logic signed [Z_W-1:0]     PI_Z         = 29'sd52707179;
	localparam logic signed [Z_W-1:0]     HALF_PI_Z    = 29'sd26353589;
	localparam logic signed [XY_W-1:0]    CORDIC_GAIN  = 20'sd39797;

	typedef enum logic [1:0] {
		OP_ACC,
		OP_CLR,
		OP_RD
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_FOLD,
		ST_CORDIC,
		ST_MULT,
		ST_PLACE,
		ST_CLAMP,
		ST_ADDR,
		ST_READ,
		ST_UPDATE,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [11:0] beam_index;
		logic [15:0] range_value;
		logic [7:0]  read_column;
		logic [6:0]  read_row;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] cell_column;
		logic [6:0] cell_row;
		logic [7:0] cell_value;
	} out_item_t;

	typedef struct packed {
		op_t                        op;
		logic signed [ANGLE_W-1:0]  alpha;
		logic [15:0]                range_value;
		logic [7:0]                 read_column;
		logic [6:0]                 read_row;
	} queue_entry_t;

	function automatic logic signed [Z_W-1:0] atan_lut(input logic [3:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			4'd0:    v = 29'sd13176795;
			4'd1:    v = 29'sd7778716;
			4'd2:    v = 29'sd4110060;
			4'd3:    v = 29'sd2086331;
			4'd4:    v = 29'sd1047214;
			4'd5:    v = 29'sd524117;
			4'd6:    v = 29'sd262123;
			4'd7:    v = 29'sd131069;
			4'd8:    v = 29'sd65536;
			4'd9:    v = 29'sd32768;
			4'd10:   v = 29'sd16384;
			4'd11:   v = 29'sd8192;
			4'd12:   v = 29'sd4096;
			4'd13:   v = 29'sd2048;
			4'd14:   v = 29'sd1024;
			default: v = 29'sd512;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/polar_scan_grid_accumulator_top.sv -----
// Top level of the polar scan grid accumulator: front end, command queue and
// back end. Depends on pscga_pkg, pscga_front, pscga_queue, pscga_back.
//
//  channel | handshake            | payload
//  in      | in_valid / in_stall   | in_data  (pscga_pkg::in_item_t)
//  out     | out_valid / out_stall | out_data (pscga_pkg::out_item_t)
//  cfg     | cfg_we                | cfg_index, cfg_data
//
// Accumulate in the back end: 11 reduction steps, 16 CORDIC iterations,
// multiply, place, clamp, cell read-modify-write, output. Read: address,
// cell read, update, output. Clear and reset: a clearing pass over the
// 128*STRETCH^2 cells of the store, one cell a cycle, in_stall high throughout.
// Dropped samples and unused commands leave at the front without a result.
// The two-entry queue lets the front take items while the back end works.
module polar_scan_grid_accumulator_top #(
	parameter int STRETCH   = 16,
	parameter int MAX_BEAMS = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [pscga_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  pscga_pkg::in_item_t              in_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pscga_pkg::out_item_t             out_data
);

	pscga_pkg::queue_entry_t push_entry, head;
	logic push, pop, full, empty, clearing;

	pscga_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.in_stall   (in_stall),
		.queue_full (full),
		.clearing   (clearing),
		.push       (push),
		.entry      (push_entry)
	);

	pscga_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (full),
		.empty      (empty)
	);

	pscga_back #(.STRETCH(STRETCH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (empty),
		.pop       (pop),
		.clearing  (clearing),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ----- rtl/pscga_front.sv -----
// Front end: configuration registers, input transfer, command classification
// and beam angle computation. Depends on pscga_pkg.
module pscga_front #(
	parameter int MAX_BEAMS = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [pscga_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	input  pscga_pkg::in_item_t                 in_data,
	output logic                                in_stall,
	input  logic                                queue_full,
	input  logic                                clearing,
	output logic                                push,
	output pscga_pkg::queue_entry_t             entry
);

	logic signed [26:0] start_q;
	logic [24:0]        step_q;
	logic [15:0]        limit_q;
	logic [36:0]        idx_prod;
	logic               keep;
	logic               drop_acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			step_q  <= '0;
			limit_q <= pscga_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pscga_pkg::CFG_START: start_q <= cfg_data;
				pscga_pkg::CFG_STEP:  step_q  <= cfg_data[24:0];
				pscga_pkg::CFG_LIMIT: limit_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign in_stall = queue_full | clearing;
	assign idx_prod = 37'(in_data.beam_index) * 37'(step_q);
	assign drop_acc = (int'({20'd0, in_data.beam_index}) >= MAX_BEAMS)
		|| (in_data.range_value > limit_q);

	always_comb begin
		entry.alpha       = pscga_pkg::ANGLE_W'(start_q) + $signed({2'b00, idx_prod});
		entry.range_value = in_data.range_value;
		entry.read_column = in_data.read_column;
		entry.read_row    = in_data.read_row;
		unique case (in_data.command)
			pscga_pkg::CMD_ACC: begin
				entry.op = pscga_pkg::OP_ACC;
				keep     = !drop_acc;
			end
			pscga_pkg::CMD_CLR: begin
				entry.op = pscga_pkg::OP_CLR;
				keep     = 1'b1;
			end
			pscga_pkg::CMD_RD: begin
				entry.op = pscga_pkg::OP_RD;
				keep     = 1'b1;
			end
			default: begin
				entry.op = pscga_pkg::OP_ACC;
				keep     = 1'b0;
			end
		endcase
	end

	assign push = in_valid & !in_stall & keep;

endmodule

// ----- rtl/pscga_queue.sv -----
// Short queue of classified commands between front and back end.
// Depends on pscga_pkg.
module pscga_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  pscga_pkg::queue_entry_t push_entry,
	input  logic                    pop,
	output pscga_pkg::queue_entry_t head,
	output logic                    full,
	output logic                    empty
);

	localparam int DEPTH = pscga_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pscga_pkg::queue_entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_entry;
	end

endmodule

// ----- rtl/pscga_back.sv -----
// Back end: angle reduction, iterative CORDIC, placement onto the grid, cell
// store with read-modify-write and clearing pass, output register. Uses pscga_pkg.
module pscga_back #(
	parameter int STRETCH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pscga_pkg::queue_entry_t head,
	input  logic                    q_empty,
	output logic                    pop,
	output logic                    clearing,
	output logic                    out_valid,
	input  logic                    out_stall,
	output pscga_pkg::out_item_t    out_data
);

	localparam int GRID_W = 16 * STRETCH;
	localparam int GRID_H = 8 * STRETCH;
	localparam int DEPTH  = GRID_W * GRID_H;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int COL_W  = $clog2(GRID_W);
	localparam int ROW_W  = $clog2(GRID_H);
	localparam int PROD_W = 37;
	localparam int TOT_W  = 46;
	localparam logic signed [TOT_W-1:0] HALF_X = TOT_W'(GRID_W / 2) <<< pscga_pkg::COORD_FRAC;
	localparam logic signed [TOT_W-1:0] HALF_Y = TOT_W'(GRID_H / 2) <<< pscga_pkg::COORD_FRAC;
	localparam logic signed [TOT_W-1:0] STRETCH_S = TOT_W'(STRETCH);

	pscga_pkg::back_state_t state_q, state_d;

	logic [ADDR_W-1:0]                      clr_addr_q;
	pscga_pkg::op_t                         op_q;
	logic                                   alpha_neg_q;
	logic [15:0]                            r_q;
	logic [pscga_pkg::RED_W-1:0]            red_q;
	logic [3:0]                             k_q;
	logic signed [pscga_pkg::Z_W-1:0]       z_q;
	logic                                   neg_q;
	logic signed [pscga_pkg::XY_W-1:0]      x_q, y_q;
	logic [3:0]                             it_q;
	logic signed [PROD_W-1:0]               ps_s1, pc_s1;
	logic signed [TOT_W-1:0]                tx_s2, ty_s2;
	logic [COL_W-1:0]                       col_q;
	logic [ROW_W-1:0]                       row_q;
	logic [ADDR_W-1:0]                      addr_q;
	logic [7:0]                             rd_q, val_q;
	logic                                   out_valid_q;
	pscga_pkg::out_item_t                   out_data_q;

	logic [7:0] cells [DEPTH];

	logic                                   out_free, out_load, mem_we;
	logic [ADDR_W-1:0]                      mem_wa;
	logic [7:0]                             mem_wd;
	logic [pscga_pkg::RED_W-1:0]            red_cmp;
	logic signed [pscga_pkg::Z_W-1:0]       z0, z1, z2;
	logic                                   fold_neg;
	logic signed [pscga_pkg::XY_W-1:0]      dx, dy, s_v, c_v;
	logic signed [16:0]                     r_s;
	logic signed [PROD_W-1:0]               apx, px;
	logic signed [TOT_W-1:0]                tx_int, ty_int;
	logic [COL_W-1:0]                       col_c, rd_col;
	logic [ROW_W-1:0]                       row_c, rd_row;
	logic [pscga_pkg::RED_W-1:0]            red_init;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pscga_pkg::ST_CLEAR:
				if (clr_addr_q == ADDR_W'(DEPTH - 1)) state_d = pscga_pkg::ST_IDLE;
			pscga_pkg::ST_IDLE:
				if (!q_empty) begin
					unique case (head.op)
						pscga_pkg::OP_ACC: state_d = pscga_pkg::ST_REDUCE;
						pscga_pkg::OP_CLR: state_d = pscga_pkg::ST_CLEAR;
						default:           state_d = pscga_pkg::ST_ADDR;
					endcase
				end
			pscga_pkg::ST_REDUCE:
				if (k_q == '0) state_d = pscga_pkg::ST_FOLD;
			pscga_pkg::ST_FOLD:   state_d = pscga_pkg::ST_CORDIC;
			pscga_pkg::ST_CORDIC:
				if (it_q == 4'(pscga_pkg::CORDIC_ITERS - 1)) state_d = pscga_pkg::ST_MULT;
			pscga_pkg::ST_MULT:   state_d = pscga_pkg::ST_PLACE;
			pscga_pkg::ST_PLACE:  state_d = pscga_pkg::ST_CLAMP;
			pscga_pkg::ST_CLAMP:  state_d = pscga_pkg::ST_ADDR;
			pscga_pkg::ST_ADDR:   state_d = pscga_pkg::ST_READ;
			pscga_pkg::ST_READ:   state_d = pscga_pkg::ST_UPDATE;
			pscga_pkg::ST_UPDATE: state_d = pscga_pkg::ST_OUT;
			pscga_pkg::ST_OUT:
				if (out_free) state_d = pscga_pkg::ST_IDLE;
			default:              state_d = pscga_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = (state_q == pscga_pkg::ST_IDLE) && !q_empty;
		clearing = (state_q == pscga_pkg::ST_CLEAR);
		out_load = (state_q == pscga_pkg::ST_OUT) && out_free;
		mem_we   = clearing
			|| ((state_q == pscga_pkg::ST_UPDATE) && (op_q == pscga_pkg::OP_ACC));
		mem_wa   = clearing ? clr_addr_q : addr_q;
		mem_wd   = clearing ? 8'd0 : rd_q + pscga_pkg::CELL_STEP;
	end

	// angle arithmetic
	always_comb begin
		red_cmp  = pscga_pkg::TWO_PI_R << k_q;
		red_init = head.alpha[pscga_pkg::ANGLE_W-1]
			? pscga_pkg::RED_W'(head.alpha + pscga_pkg::TWO_PI_A)
			: pscga_pkg::RED_W'(head.alpha);
		z0 = $signed(pscga_pkg::Z_W'(red_q));
		z1 = (z0 > pscga_pkg::PI_Z) ? z0 - pscga_pkg::TWO_PI_Z : z0;
		fold_neg = 1'b0;
		z2 = z1;
		if (z1 > pscga_pkg::HALF_PI_Z) begin
			z2 = z1 - pscga_pkg::PI_Z;
			fold_neg = 1'b1;
		end else if (z1 < -pscga_pkg::HALF_PI_Z) begin
			z2 = z1 + pscga_pkg::PI_Z;
			fold_neg = 1'b1;
		end
		dx  = y_q >>> it_q;
		dy  = x_q >>> it_q;
		s_v = neg_q ? -y_q : y_q;
		c_v = neg_q ? -x_q : x_q;
		r_s = $signed({1'b0, r_q});
		apx = (ps_s1 < 0) ? -ps_s1 : ps_s1;
		px  = alpha_neg_q ? -apx : apx;
	end

	// truncation and clamping to the grid
	always_comb begin
		tx_int = tx_s2 >>> pscga_pkg::COORD_FRAC;
		ty_int = ty_s2 >>> pscga_pkg::COORD_FRAC;
		if (tx_s2 < 0)                          col_c = '0;
		else if (tx_int > TOT_W'(GRID_W - 1))   col_c = COL_W'(GRID_W - 1);
		else                                    col_c = tx_int[COL_W-1:0];
		if (ty_s2 < 0)                          row_c = '0;
		else if (ty_int > TOT_W'(GRID_H - 1))   row_c = ROW_W'(GRID_H - 1);
		else                                    row_c = ty_int[ROW_W-1:0];
		rd_col = (int'({24'd0, head.read_column}) > GRID_W - 1)
			? COL_W'(GRID_W - 1) : COL_W'(head.read_column);
		rd_row = (int'({25'd0, head.read_row}) > GRID_H - 1)
			? ROW_W'(GRID_H - 1) : ROW_W'(head.read_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pscga_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing)
				clr_addr_q <= clr_addr_q + 1'b1;
			else
				clr_addr_q <= '0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pscga_pkg::ST_IDLE: begin
				op_q        <= head.op;
				alpha_neg_q <= head.alpha[pscga_pkg::ANGLE_W-1];
				r_q         <= head.range_value;
				red_q       <= red_init;
				k_q         <= 4'(pscga_pkg::RED_STEPS - 1);
				col_q       <= rd_col;
				row_q       <= rd_row;
			end
			pscga_pkg::ST_REDUCE: begin
				if (red_q >= red_cmp) red_q <= red_q - red_cmp;
				k_q <= k_q - 1'b1;
			end
			pscga_pkg::ST_FOLD: begin
				z_q   <= z2;
				neg_q <= fold_neg;
				x_q   <= pscga_pkg::CORDIC_GAIN;
				y_q   <= '0;
				it_q  <= '0;
			end
			pscga_pkg::ST_CORDIC: begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - pscga_pkg::atan_lut(it_q);
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + pscga_pkg::atan_lut(it_q);
				end
				it_q <= it_q + 1'b1;
			end
			pscga_pkg::ST_MULT: begin
				ps_s1 <= PROD_W'(r_s * s_v);
				pc_s1 <= PROD_W'(r_s * c_v);
			end
			pscga_pkg::ST_PLACE: begin
				tx_s2 <= HALF_X + STRETCH_S * TOT_W'(px);
				ty_s2 <= HALF_Y + STRETCH_S * TOT_W'(pc_s1);
			end
			pscga_pkg::ST_CLAMP: begin
				col_q <= col_c;
				row_q <= row_c;
			end
			pscga_pkg::ST_ADDR:
				addr_q <= ADDR_W'(row_q * GRID_W) + ADDR_W'(col_q);
			pscga_pkg::ST_UPDATE:
				val_q <= (op_q == pscga_pkg::OP_ACC) ? rd_q + pscga_pkg::CELL_STEP : rd_q;
			default: ;
		endcase
		if (out_load) begin
			out_data_q.result_kind <= (op_q == pscga_pkg::OP_RD)
				? pscga_pkg::RES_READ : pscga_pkg::RES_POINT;
			out_data_q.cell_column <= 8'(col_q);
			out_data_q.cell_row    <= 7'(row_q);
			out_data_q.cell_value  <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			cells[mem_wa] <= mem_wd;
		if (state_q == pscga_pkg::ST_READ)
			rd_q <= cells[addr_q];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_reduce_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pscga_pkg::ST_REDUCE && k_q == '0) |=> (state_q == pscga_pkg::ST_FOLD))
		else $error("reduction did not end after its last step");

	a_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pscga_pkg::ST_FOLD) |-> (red_q < pscga_pkg::TWO_PI_R))
		else $error("angle not reduced below two pi");

	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == pscga_pkg::ST_CLEAR
			|| (state_q == pscga_pkg::ST_UPDATE && op_q == pscga_pkg::OP_ACC)))
		else $error("cell store written outside clear or update");

	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pscga_pkg::ST_OUT && out_valid_q && out_stall)
			|=> (state_q == pscga_pkg::ST_OUT))
		else $error("result overwrote a pending transfer");

endmodule
